### sv/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define BSD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");

// Clocked assertion, also checked during reset
`define BSD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("%m failed");

`endif

### sv/bmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_pkg
// Types, constants and status codes of the BMP byte stream decoder.
// ----------------------------------------------------------------------------
package bmp_pkg;

   localparam int unsigned MAX_WIDTH_DEF       = 4096;
   localparam int unsigned MAX_HEIGHT_DEF      = 4096;
   localparam int unsigned PALETTE_ENTRIES_DEF = 256;

   localparam logic [15:0] SIGNATURE     = 16'h4d42;
   localparam logic [31:0] HDR_SIZE_INFO = 32'd40;
   localparam logic [31:0] HDR_SIZE_CORE = 32'd12;
   localparam logic [8:0]  PAL_FULL      = 9'd256;

   // header byte positions, taken on the last byte of each field
   localparam logic [5:0] OFS_SIG       = 6'd1;
   localparam logic [5:0] OFS_HDR_SIZE  = 6'd17;
   localparam logic [5:0] OFS_CORE_W    = 6'd19;
   localparam logic [5:0] OFS_CORE_H    = 6'd21;
   localparam logic [5:0] OFS_CORE_BPP  = 6'd25;
   localparam logic [5:0] OFS_INFO_W    = 6'd21;
   localparam logic [5:0] OFS_INFO_H    = 6'd25;
   localparam logic [5:0] OFS_INFO_BPP  = 6'd29;
   localparam logic [5:0] OFS_INFO_COMP = 6'd33;
   localparam logic [5:0] OFS_INFO_CLR  = 6'd49;
   localparam logic [5:0] OFS_INFO_END  = 6'd53;

   localparam logic [15:0] BPP_8  = 16'd8;
   localparam logic [15:0] BPP_24 = 16'd24;

   localparam logic [3:0] ST_OK         = 4'd0;
   localparam logic [3:0] ST_SHORT_HDR  = 4'd1;
   localparam logic [3:0] ST_BAD_SIG    = 4'd2;
   localparam logic [3:0] ST_BAD_HDR    = 4'd3;
   localparam logic [3:0] ST_BAD_DEPTH  = 4'd4;
   localparam logic [3:0] ST_COMPRESSED = 4'd5;
   localparam logic [3:0] ST_SHORT_PIX  = 4'd6;
   localparam logic [3:0] ST_PAL_BIG    = 4'd7;
   localparam logic [3:0] ST_TOO_LARGE  = 4'd8;

   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_HDR  = 5'b00010,
      PH_PAL  = 5'b00100,
      PH_PIX  = 5'b01000,
      PH_PAD  = 5'b10000
   } phase_type;

endpackage

### sv/bmp_byte_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_byte_stream_decoder
// Parses a BMP file byte by byte and emits each decoded pixel or an error.
// ----------------------------------------------------------------------------
// Path: an accepted byte goes into the input register, then its result into
// the result register, with the palette read register beside it.
// Throughput: one byte per cycle; the input is held only while a result waits.
// Reset: synchronous, active high; clears the parser, the palette memory is
// not cleared and is only read at entries written for the current file.
module bmp_byte_stream_decoder #(
   parameter int unsigned MAX_WIDTH       = bmp_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT      = bmp_pkg::MAX_HEIGHT_DEF,
   parameter int unsigned PALETTE_ENTRIES = bmp_pkg::PALETTE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // data_byte
   input  logic        req_tuser,  // file_start
   input  logic        req_tlast,  // file_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // pos_x[11:0], pos_y[23:12], red, green, blue
   output logic [4:0]  rsp_tuser,  // pixel_valid[0], status[4:1]
   output logic        rsp_tlast   // last_pixel
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int WH = $clog2(MAX_HEIGHT + 1);
   localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff, in_end_ff;

   // parser state
   bmp_pkg::phase_type phase_ff, phase_in;
   logic [5:0]    byte_count_ff, byte_count_in;
   logic [31:0]   field_shift_ff, field_shift_in;
   logic          core_format_ff, core_format_in;
   logic [WW-1:0] image_width_ff, image_width_in;
   logic [WH-1:0] image_height_ff, image_height_in;
   logic          width_big_ff, width_big_in;
   logic          height_big_ff, height_big_in;
   logic          eight_bit_ff, eight_bit_in;
   logic          depth_bad_ff, depth_bad_in;
   logic          compressed_ff, compressed_in;
   logic [8:0]    colors_used_ff, colors_used_in;
   logic          colors_nz_ff, colors_nz_in;
   logic          colors_big_ff, colors_big_in;
   logic [8:0]    palette_count_ff, palette_count_in;
   logic [8:0]    pal_index_ff, pal_index_in;
   logic [WW-1:0] col_count_ff, col_count_in;
   logic [WH-1:0] row_count_ff, row_count_in;
   logic [1:0]    component_count_ff, component_count_in;
   logic [15:0]   partial_color_ff, partial_color_in;
   logic [1:0]    pad_count_ff, pad_count_in;
   logic [1:0]    row_pad_ff, row_pad_in;

   // result register
   logic        out_valid_ff;
   logic        res_pix_ff, res_last_ff, res_mem_ff;
   logic [11:0] res_x_ff, res_y_ff;
   logic [23:0] res_rgb_ff;
   logic [3:0]  res_status_ff;
   logic [23:0] pal_q_ff;

   // per-item result
   logic        res_any, res_pix, res_last, res_mem;
   logic [11:0] res_x, res_y;
   logic [23:0] res_rgb;
   logic [3:0]  res_status;
   logic        pal_we;
   logic [23:0] pal_wdata;
   logic [23:0] pal_mem [PALETTE_ENTRIES];

   logic advance, consume;
   logic [3:0]  err;
   logic [5:0]  n;
   logic [1:0]  wlow;
   logic [WW-1:0] col_next;
   logic [WH-1:0] row_next;

   assign advance    = !out_valid_ff || rsp_tready;
   assign consume    = in_valid_ff && advance;
   assign req_tready = advance || !in_valid_ff;

   always_comb begin
      phase_in           = phase_ff;
      byte_count_in      = byte_count_ff;
      field_shift_in     = field_shift_ff;
      core_format_in     = core_format_ff;
      image_width_in     = image_width_ff;
      image_height_in    = image_height_ff;
      width_big_in       = width_big_ff;
      height_big_in      = height_big_ff;
      eight_bit_in       = eight_bit_ff;
      depth_bad_in       = depth_bad_ff;
      compressed_in      = compressed_ff;
      colors_used_in     = colors_used_ff;
      colors_nz_in       = colors_nz_ff;
      colors_big_in      = colors_big_ff;
      palette_count_in   = palette_count_ff;
      pal_index_in       = pal_index_ff;
      col_count_in       = col_count_ff;
      row_count_in       = row_count_ff;
      component_count_in = component_count_ff;
      partial_color_in   = partial_color_ff;
      pad_count_in       = pad_count_ff;
      row_pad_in         = row_pad_ff;
      res_any    = 1'b0;
      res_pix    = 1'b0;
      res_last   = 1'b0;
      res_mem    = 1'b0;
      res_x      = '0;
      res_y      = '0;
      res_rgb    = '0;
      res_status = bmp_pkg::ST_OK;
      pal_we     = 1'b0;
      pal_wdata  = '0;
      err        = bmp_pkg::ST_OK;
      n          = '0;
      wlow       = '0;
      col_next   = '0;
      row_next   = '0;

      if (in_start_ff) begin
         phase_in           = bmp_pkg::PH_HDR;
         byte_count_in      = '0;
         field_shift_in     = '0;
         core_format_in     = 1'b0;
         image_width_in     = '0;
         image_height_in    = '0;
         width_big_in       = 1'b0;
         height_big_in      = 1'b0;
         eight_bit_in       = 1'b0;
         depth_bad_in       = 1'b0;
         compressed_in      = 1'b0;
         colors_used_in     = '0;
         colors_nz_in       = 1'b0;
         colors_big_in      = 1'b0;
         palette_count_in   = '0;
         pal_index_in       = '0;
         col_count_in       = '0;
         row_count_in       = '0;
         component_count_in = '0;
         partial_color_in   = '0;
         pad_count_in       = '0;
         row_pad_in         = '0;
      end

      unique case (phase_in)
         bmp_pkg::PH_HDR: begin
            n              = byte_count_in;
            field_shift_in = {in_byte_ff, field_shift_in[31:8]};
            byte_count_in  = byte_count_in + 6'd1;
            if (n == bmp_pkg::OFS_SIG) begin
               if (field_shift_in[31:16] != bmp_pkg::SIGNATURE) err = bmp_pkg::ST_BAD_SIG;
            end else if (n == bmp_pkg::OFS_HDR_SIZE) begin
               if (field_shift_in == bmp_pkg::HDR_SIZE_INFO) core_format_in = 1'b0;
               else if (field_shift_in == bmp_pkg::HDR_SIZE_CORE) core_format_in = 1'b1;
               else err = bmp_pkg::ST_BAD_HDR;
            end else if (core_format_in) begin
               if (n == bmp_pkg::OFS_CORE_W) begin
                  image_width_in = WW'(field_shift_in[31:16]);
                  width_big_in   = {16'd0, field_shift_in[31:16]} > 32'(MAX_WIDTH);
               end else if (n == bmp_pkg::OFS_CORE_H) begin
                  image_height_in = WH'(field_shift_in[31:16]);
                  height_big_in   = {16'd0, field_shift_in[31:16]} > 32'(MAX_HEIGHT);
               end else if (n == bmp_pkg::OFS_CORE_BPP) begin
                  eight_bit_in = field_shift_in[31:16] == bmp_pkg::BPP_8;
                  depth_bad_in = field_shift_in[31:16] != bmp_pkg::BPP_8
                                 && field_shift_in[31:16] != bmp_pkg::BPP_24;
                  n = bmp_pkg::OFS_INFO_END;
               end
            end else begin
               if (n == bmp_pkg::OFS_INFO_W) begin
                  image_width_in = WW'(field_shift_in);
                  width_big_in   = field_shift_in > 32'(MAX_WIDTH);
               end else if (n == bmp_pkg::OFS_INFO_H) begin
                  image_height_in = WH'(field_shift_in);
                  height_big_in   = field_shift_in > 32'(MAX_HEIGHT);
               end else if (n == bmp_pkg::OFS_INFO_BPP) begin
                  eight_bit_in = field_shift_in[31:16] == bmp_pkg::BPP_8;
                  depth_bad_in = field_shift_in[31:16] != bmp_pkg::BPP_8
                                 && field_shift_in[31:16] != bmp_pkg::BPP_24;
               end else if (n == bmp_pkg::OFS_INFO_COMP) begin
                  compressed_in = field_shift_in != 32'd0;
               end else if (n == bmp_pkg::OFS_INFO_CLR) begin
                  colors_used_in = field_shift_in[8:0];
                  colors_nz_in   = field_shift_in != 32'd0;
                  colors_big_in  = field_shift_in > 32'(PALETTE_ENTRIES);
               end
            end
            // header complete
            if (err == bmp_pkg::ST_OK && n == bmp_pkg::OFS_INFO_END) begin
               if (depth_bad_in) err = bmp_pkg::ST_BAD_DEPTH;
               else if (compressed_in) err = bmp_pkg::ST_COMPRESSED;
               else if (width_big_in || height_big_in) err = bmp_pkg::ST_TOO_LARGE;
               else if (colors_nz_in) begin
                  if (colors_big_in) err = bmp_pkg::ST_PAL_BIG;
                  else palette_count_in = colors_used_in;
               end else begin
                  palette_count_in = eight_bit_in ? bmp_pkg::PAL_FULL : 9'd0;
                  if (eight_bit_in && 32'(PALETTE_ENTRIES) < 32'd256)
                     err = bmp_pkg::ST_PAL_BIG;
               end
               if (err == bmp_pkg::ST_OK) begin
                  pal_index_in       = '0;
                  component_count_in = '0;
                  partial_color_in   = '0;
                  if (palette_count_in != 9'd0) phase_in = bmp_pkg::PH_PAL;
                  else begin
                     col_count_in = '0;
                     row_count_in = '0;
                     wlow = 2'(image_width_in);
                     row_pad_in = eight_bit_in ? 2'(3'd4 - {1'b0, wlow}) : wlow;
                     if (image_width_in == '0 || image_height_in == '0)
                        phase_in = bmp_pkg::PH_IDLE;
                     else phase_in = bmp_pkg::PH_PIX;
                  end
               end
            end
            if (err != bmp_pkg::ST_OK) begin
               res_any    = 1'b1;
               res_status = err;
               phase_in   = bmp_pkg::PH_IDLE;
            end
         end
         bmp_pkg::PH_PAL: begin
            unique case (component_count_in)
               2'd0: partial_color_in = {8'd0, in_byte_ff};
               2'd1: partial_color_in[15:8] = in_byte_ff;
               2'd2: begin
                  pal_we    = 1'b1;
                  pal_wdata = {in_byte_ff, partial_color_in};
               end
               default: ;
            endcase
            if ((component_count_in == 2'd2 && core_format_in) || component_count_in == 2'd3)
            begin
               component_count_in = '0;
               pal_index_in       = pal_index_in + 9'd1;
               if (pal_index_in >= palette_count_in) begin
                  col_count_in       = '0;
                  row_count_in       = '0;
                  partial_color_in   = '0;
                  wlow = 2'(image_width_in);
                  row_pad_in = eight_bit_in ? 2'(3'd4 - {1'b0, wlow}) : wlow;
                  if (image_width_in == '0 || image_height_in == '0)
                     phase_in = bmp_pkg::PH_IDLE;
                  else phase_in = bmp_pkg::PH_PIX;
               end
            end else begin
               component_count_in = component_count_in + 2'd1;
            end
         end
         bmp_pkg::PH_PIX: begin
            if (eight_bit_in) begin
               res_any = 1'b1;
               res_mem = {1'b0, in_byte_ff} < palette_count_in;
            end else if (component_count_in == 2'd0) begin
               partial_color_in   = {8'd0, in_byte_ff};
               component_count_in = 2'd1;
            end else if (component_count_in == 2'd1) begin
               partial_color_in[15:8] = in_byte_ff;
               component_count_in     = 2'd2;
            end else begin
               component_count_in = '0;
               res_any = 1'b1;
               res_rgb = {in_byte_ff, partial_color_in};
            end
            if (res_any) begin
               res_pix  = 1'b1;
               res_x    = 12'(col_count_in);
               res_y    = 12'(image_height_in - WH'(1) - row_count_in);
               col_next = col_count_in + WW'(1);
               row_next = row_count_in + WH'(1);
               col_count_in = col_next;
               if (col_next >= image_width_in) begin
                  col_count_in = '0;
                  if (row_next >= image_height_in) begin
                     res_last = 1'b1;
                     phase_in = bmp_pkg::PH_IDLE;
                  end else begin
                     row_count_in = row_next;
                     if (row_pad_in != 2'd0) begin
                        pad_count_in = row_pad_in;
                        phase_in     = bmp_pkg::PH_PAD;
                     end
                  end
               end
            end
         end
         bmp_pkg::PH_PAD: begin
            pad_count_in = pad_count_in - 2'd1;
            if (pad_count_in == 2'd0) phase_in = bmp_pkg::PH_PIX;
         end
         default: ;
      endcase

      if (in_end_ff && phase_in != bmp_pkg::PH_IDLE) begin
         if (res_any) res_status = bmp_pkg::ST_SHORT_PIX;
         else begin
            res_any    = 1'b1;
            res_status = (phase_in == bmp_pkg::PH_HDR || phase_in == bmp_pkg::PH_PAL)
                         ? bmp_pkg::ST_SHORT_HDR : bmp_pkg::ST_SHORT_PIX;
         end
         phase_in = bmp_pkg::PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         phase_ff           <= bmp_pkg::PH_IDLE;
         byte_count_ff      <= '0;
         field_shift_ff     <= '0;
         core_format_ff     <= 1'b0;
         image_width_ff     <= '0;
         image_height_ff    <= '0;
         width_big_ff       <= 1'b0;
         height_big_ff      <= 1'b0;
         eight_bit_ff       <= 1'b0;
         depth_bad_ff       <= 1'b0;
         compressed_ff      <= 1'b0;
         colors_used_ff     <= '0;
         colors_nz_ff       <= 1'b0;
         colors_big_ff      <= 1'b0;
         palette_count_ff   <= '0;
         pal_index_ff       <= '0;
         col_count_ff       <= '0;
         row_count_ff       <= '0;
         component_count_ff <= '0;
         partial_color_ff   <= '0;
         pad_count_ff       <= '0;
         row_pad_ff         <= '0;
      end else begin
         if (req_tvalid && req_tready) in_valid_ff <= 1'b1;
         else if (consume) in_valid_ff <= 1'b0;
         if (advance) out_valid_ff <= consume && res_any;
         if (consume) begin
            phase_ff           <= phase_in;
            byte_count_ff      <= byte_count_in;
            field_shift_ff     <= field_shift_in;
            core_format_ff     <= core_format_in;
            image_width_ff     <= image_width_in;
            image_height_ff    <= image_height_in;
            width_big_ff       <= width_big_in;
            height_big_ff      <= height_big_in;
            eight_bit_ff       <= eight_bit_in;
            depth_bad_ff       <= depth_bad_in;
            compressed_ff      <= compressed_in;
            colors_used_ff     <= colors_used_in;
            colors_nz_ff       <= colors_nz_in;
            colors_big_ff      <= colors_big_in;
            palette_count_ff   <= palette_count_in;
            pal_index_ff       <= pal_index_in;
            col_count_ff       <= col_count_in;
            row_count_ff       <= row_count_in;
            component_count_ff <= component_count_in;
            partial_color_ff   <= partial_color_in;
            pad_count_ff       <= pad_count_in;
            row_pad_ff         <= row_pad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
         in_end_ff   <= req_tlast;
      end
      if (consume && advance) begin
         res_pix_ff    <= res_pix;
         res_last_ff   <= res_last;
         res_mem_ff    <= res_mem;
         res_x_ff      <= res_x;
         res_y_ff      <= res_y;
         res_rgb_ff    <= res_rgb;
         res_status_ff <= res_status;
      end
   end

   // palette memory, registered read
   always_ff @(posedge clock) begin
      if (consume && pal_we) pal_mem[pal_index_ff[AW-1:0]] <= pal_wdata;
      if (consume) pal_q_ff <= pal_mem[in_byte_ff[AW-1:0]];
   end

   logic [23:0] rgb_out;
   assign rgb_out    = res_mem_ff ? pal_q_ff : res_rgb_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {rgb_out[7:0], rgb_out[15:8], rgb_out[23:16], res_y_ff, res_x_ff};
   assign rsp_tuser  = {res_status_ff, res_pix_ff};
   assign rsp_tlast  = res_last_ff;

endmodule

### sv/bmp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_checker
// Port-level checks of the BMP byte stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [4:0]  rsp_tuser,
   input logic        rsp_tlast
);

   `BSD_ASSERT(pix_status_ok, clock, reset, rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[4:1] == bmp_pkg::ST_OK || rsp_tuser[4:1] == bmp_pkg::ST_SHORT_PIX)
   `BSD_ASSERT(err_is_empty, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tuser[4:1] != bmp_pkg::ST_OK && rsp_tdata == 48'd0 && !rsp_tlast)
   `BSD_ASSERT(rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `BSD_ASSERT_ALWAYS(reset_quiet, clock, $past(reset) |-> !rsp_tvalid)

endmodule

bind bmp_byte_stream_decoder bmp_checker u_bmp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### sim/bmp_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_pixel_checker
// Watches both streams of the BMP decoder, works out the pixel or error
// result that each accepted byte gives and compares the results in order.
// ----------------------------------------------------------------------------
module bmp_pixel_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // file_start
   input  logic        req_tlast,   // file_end
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // pos_x, pos_y, red, green, blue
   input  logic [4:0]  rsp_tuser,   // pixel_valid, status
   input  logic        rsp_tlast,   // last_pixel
   output int          fail_count,
   output int          pending,
   output int          pixels_seen,
   output int          errors_seen
);

   typedef struct packed {
      logic        pix_valid;
      logic [11:0] x;
      logic [11:0] y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        last;
      logic [3:0]  status;
   } pixel_result_type;

   pixel_result_type pixel_expect_q[$];

   bmp_pkg::phase_type ph;
   logic [5:0]  bcnt;
   logic [31:0] shf, wid, hgt, clr, pcount, pidx, col, row;
   logic        core, eight, dbad, comp;
   logic [1:0]  cc, padc, rpad;
   logic [15:0] part;
   logic [23:0] pal [256];

   assign pending = pixel_expect_q.size();

   task clear_parser();
      ph = bmp_pkg::PH_IDLE; bcnt = '0; shf = '0; core = 0; wid = '0; hgt = '0;
      eight = 0; dbad = 0; comp = 0; clr = '0; pcount = '0; pidx = '0;
      col = '0; row = '0; cc = '0; part = '0; padc = '0; rpad = '0;
   endtask

   function automatic void start_pixels();
      col = '0; row = '0; cc = '0; part = '0;
      if (wid == 0 || hgt == 0) begin
         ph = bmp_pkg::PH_IDLE;
      end else begin
         rpad = eight ? 2'((4 - (wid & 3)) & 3) : 2'(wid & 3);
         ph = bmp_pkg::PH_PIX;
      end
   endfunction

   function automatic logic [3:0] finish_header();
      if (dbad) return bmp_pkg::ST_BAD_DEPTH;
      if (comp) return bmp_pkg::ST_COMPRESSED;
      if (wid > bmp_pkg::MAX_WIDTH_DEF || hgt > bmp_pkg::MAX_HEIGHT_DEF)
         return bmp_pkg::ST_TOO_LARGE;
      if (clr != 0) begin
         if (clr > bmp_pkg::PALETTE_ENTRIES_DEF) return bmp_pkg::ST_PAL_BIG;
         pcount = clr;
      end else begin
         pcount = eight ? 32'(bmp_pkg::PAL_FULL) : 32'd0;
      end
      pidx = '0; cc = '0; part = '0;
      if (pcount != 0) ph = bmp_pkg::PH_PAL;
      else start_pixels();
      return bmp_pkg::ST_OK;
   endfunction

   function automatic logic [3:0] header_byte(logic [7:0] b);
      logic [5:0] n;
      logic [15:0] bpp;
      n = bcnt;
      shf = {b, shf[31:8]};
      bcnt = bcnt + 6'd1;
      bpp = shf[31:16];
      if (n == bmp_pkg::OFS_SIG) begin
         if (shf[31:16] != bmp_pkg::SIGNATURE) return bmp_pkg::ST_BAD_SIG;
      end else if (n == bmp_pkg::OFS_HDR_SIZE) begin
         if (shf == bmp_pkg::HDR_SIZE_INFO) core = 0;
         else if (shf == bmp_pkg::HDR_SIZE_CORE) core = 1;
         else return bmp_pkg::ST_BAD_HDR;
      end else if (core) begin
         if (n == bmp_pkg::OFS_CORE_W) wid = {16'd0, shf[31:16]};
         else if (n == bmp_pkg::OFS_CORE_H) hgt = {16'd0, shf[31:16]};
         else if (n == bmp_pkg::OFS_CORE_BPP) begin
            eight = (bpp == bmp_pkg::BPP_8);
            dbad = (bpp != bmp_pkg::BPP_8 && bpp != bmp_pkg::BPP_24);
            return finish_header();
         end
      end else begin
         if (n == bmp_pkg::OFS_INFO_W) wid = shf;
         else if (n == bmp_pkg::OFS_INFO_H) hgt = shf;
         else if (n == bmp_pkg::OFS_INFO_BPP) begin
            eight = (bpp == bmp_pkg::BPP_8);
            dbad = (bpp != bmp_pkg::BPP_8 && bpp != bmp_pkg::BPP_24);
         end
         else if (n == bmp_pkg::OFS_INFO_COMP) comp = (shf != 0);
         else if (n == bmp_pkg::OFS_INFO_CLR) clr = shf;
         else if (n == bmp_pkg::OFS_INFO_END) return finish_header();
      end
      return bmp_pkg::ST_OK;
   endfunction

   task palette_byte(input logic [7:0] b);
      logic done;
      done = 0;
      case (cc)
         2'd0: part = {8'd0, b};
         2'd1: part[15:8] = b;
         2'd2: begin
            pal[pidx[7:0]] = {b, part};
            done = core;
         end
         default: done = 1;
      endcase
      cc = cc + 2'd1;
      if (done) begin
         cc = '0;
         pidx = pidx + 1;
         if (pidx >= pcount) start_pixels();
      end
   endtask

   function automatic pixel_result_type emit_pixel(logic [23:0] rgb);
      pixel_result_type r;
      r = '0;
      r.pix_valid = 1;
      r.x = col[11:0];
      r.y = 12'(hgt - 1 - row);
      r.red = rgb[23:16];
      r.green = rgb[15:8];
      r.blue = rgb[7:0];
      col = col + 1;
      if (col >= wid) begin
         col = '0;
         if (row + 1 >= hgt) begin
            r.last = 1;
            ph = bmp_pkg::PH_IDLE;
         end else begin
            row = row + 1;
            if (rpad != 0) begin
               padc = rpad;
               ph = bmp_pkg::PH_PAD;
            end
         end
      end
      return r;
   endfunction

   task predict_byte(input logic [7:0] b, input logic fs, input logic fe);
      pixel_result_type r;
      logic has;
      logic [3:0] err;
      has = 0;
      r = '0;
      if (fs) begin
         clear_parser();
         ph = bmp_pkg::PH_HDR;
      end
      case (ph)
         bmp_pkg::PH_HDR: begin
            err = header_byte(b);
            if (err != bmp_pkg::ST_OK) begin
               r.status = err;
               ph = bmp_pkg::PH_IDLE;
               has = 1;
            end
         end
         bmp_pkg::PH_PAL: palette_byte(b);
         bmp_pkg::PH_PIX: begin
            if (eight) begin
               r = emit_pixel((b < pcount) ? pal[b] : 24'd0);
               has = 1;
            end else if (cc == 0) begin
               part = {8'd0, b};
               cc = 1;
            end else if (cc == 1) begin
               part[15:8] = b;
               cc = 2;
            end else begin
               cc = 0;
               r = emit_pixel({b, part});
               has = 1;
            end
         end
         bmp_pkg::PH_PAD: begin
            padc = padc - 2'd1;
            if (padc == 0) ph = bmp_pkg::PH_PIX;
         end
         default: ;
      endcase
      if (fe && ph != bmp_pkg::PH_IDLE) begin
         if (has) begin
            r.status = bmp_pkg::ST_SHORT_PIX;
         end else begin
            r = '0;
            r.status = (ph == bmp_pkg::PH_HDR || ph == bmp_pkg::PH_PAL)
                       ? bmp_pkg::ST_SHORT_HDR : bmp_pkg::ST_SHORT_PIX;
            has = 1;
         end
         ph = bmp_pkg::PH_IDLE;
      end
      if (has) pixel_expect_q.push_back(r);
   endtask

   initial begin
      fail_count = 0;
      pixels_seen = 0;
      errors_seen = 0;
      clear_parser();
      foreach (pal[i]) pal[i] = '0;
   end

   always @(posedge clock) begin
      pixel_result_type got, exp_r;
      if (!reset) begin
         if (req_tvalid && req_tready) predict_byte(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got.pix_valid = rsp_tuser[0];
            got.status = rsp_tuser[4:1];
            got.x = rsp_tdata[11:0];
            got.y = rsp_tdata[23:12];
            got.red = rsp_tdata[31:24];
            got.green = rsp_tdata[39:32];
            got.blue = rsp_tdata[47:40];
            got.last = rsp_tlast;
            if (got.pix_valid) pixels_seen++;
            else errors_seen++;
            if (pixel_expect_q.size() == 0) begin
               $display("%0t: result expected none actual %h", $time, got);
               fail_count++;
            end else begin
               exp_r = pixel_expect_q.pop_front();
               if (got.pix_valid !== exp_r.pix_valid)
                  $display("%0t: pixel_valid expected %0d actual %0d", $time,
                           exp_r.pix_valid, got.pix_valid);
               if (got.x !== exp_r.x)
                  $display("%0t: pos_x expected %0d actual %0d", $time, exp_r.x, got.x);
               if (got.y !== exp_r.y)
                  $display("%0t: pos_y expected %0d actual %0d", $time, exp_r.y, got.y);
               if (got.red !== exp_r.red)
                  $display("%0t: red expected %h actual %h", $time, exp_r.red, got.red);
               if (got.green !== exp_r.green)
                  $display("%0t: green expected %h actual %h", $time,
                           exp_r.green, got.green);
               if (got.blue !== exp_r.blue)
                  $display("%0t: blue expected %h actual %h", $time, exp_r.blue, got.blue);
               if (got.last !== exp_r.last)
                  $display("%0t: last_pixel expected %0d actual %0d", $time,
                           exp_r.last, got.last);
               if (got.status !== exp_r.status)
                  $display("%0t: status expected %0d actual %0d", $time,
                           exp_r.status, got.status);
               if (got !== exp_r) fail_count++;
            end
         end
      end
   end

endmodule

### sim/tb_bmp_byte_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bmp_byte_stream_decoder
// Streams well-formed, damaged and cut-short BMP files of both header kinds
// and both depths into the decoder with random gaps and back-pressure; the
// checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_bmp_byte_stream_decoder;

   localparam int LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // data_byte
   logic        req_tuser = 0;    // file_start
   logic        req_tlast = 0;    // file_end
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;        // pos_x, pos_y, red, green, blue
   logic [4:0]  rsp_tuser;        // pixel_valid, status
   logic        rsp_tlast;        // last_pixel

   int fail_count, pending, pixels_seen, errors_seen;
   int cycles = 0;
   int bytes_sent = 0;
   int files_sent = 0;
   bit calm;
   logic [7:0] img[$];

   always #10 clock = ~clock;

   assign calm = (bytes_sent >= 700 && bytes_sent < 1000);

   bmp_byte_stream_decoder u_top (.*);

   bmp_pixel_checker u_chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_tready <= calm || ($urandom_range(99) >= 31);
      if (cycles > LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task push16(input logic [15:0] v);
      img.push_back(v[7:0]); img.push_back(v[15:8]);
   endtask

   task push32(input logic [31:0] v);
      push16(v[15:0]); push16(v[31:16]);
   endtask

   task build_file(input bit core_h, input logic [15:0] bpp, input logic [31:0] cmp,
                   input logic [31:0] w, input logic [31:0] h, input logic [31:0] clr_v,
                   input bit bad_sig, input logic [31:0] hsize);
      int n, row_bytes, pad, bpx;
      img.delete();
      push16(bad_sig ? (bmp_pkg::SIGNATURE ^ 16'(1 << $urandom_range(15)))
                     : bmp_pkg::SIGNATURE);
      repeat (12) img.push_back(8'($urandom));
      push32(hsize);
      if (core_h) begin
         push16(w[15:0]); push16(h[15:0]); push16(16'd1); push16(bpp);
      end else begin
         push32(w); push32(h); push16(16'd1); push16(bpp); push32(cmp);
         repeat (3) push32($urandom);
         push32(clr_v); push32($urandom);
      end
      n = (core_h || clr_v == 0) ? ((bpp == bmp_pkg::BPP_8) ? 256 : 0) : int'(clr_v);
      if (n > 256) n = 0;
      repeat (n) repeat (core_h ? 3 : 4) img.push_back(8'($urandom));
      if (w <= 16 && h <= 16) begin
         bpx = (bpp == bmp_pkg::BPP_8) ? 1 : 3;
         row_bytes = int'(w) * bpx;
         pad = (4 - row_bytes % 4) % 4;
         repeat (h) begin
            repeat (row_bytes)
               img.push_back(($urandom_range(1) && bpp == bmp_pkg::BPP_8) ?
                             8'($urandom_range(n + 2 > 255 ? 255 : n + 2)) : 8'($urandom));
            repeat (pad) img.push_back(8'($urandom));
         end
      end
   endtask

   task put_byte(input logic [7:0] b, input logic fs, input logic fe);
      while (!calm && $urandom_range(99) < 31) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= b;
      req_tuser <= fs;
      req_tlast <= fe;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // cut: length to send (0 for whole file); mark the final byte as file end
   task send_file(input int cut, input bit mark_end, input int trailing);
      int len;
      len = (cut > 0 && cut < img.size()) ? cut : img.size();
      for (int i = 0; i < len; i++)
         put_byte(img[i], i == 0, (i == len - 1) && (mark_end || cut > 0));
      repeat (trailing) put_byte(8'($urandom), 0, $urandom_range(1));
      files_sent++;
   endtask

   task random_file();
      int r, w, h;
      r = $urandom_range(99);
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      if (r < 22) build_file(0, bmp_pkg::BPP_24, 0, w, h, 0, 0, bmp_pkg::HDR_SIZE_INFO);
      else if (r < 40) build_file(0, bmp_pkg::BPP_8, 0, w, h, $urandom_range(1, 20), 0,
                                  bmp_pkg::HDR_SIZE_INFO);
      else if (r < 48) build_file(1, bmp_pkg::BPP_24, 0, w, h, 0, 0, bmp_pkg::HDR_SIZE_CORE);
      else if (r < 50) build_file(1, bmp_pkg::BPP_8, 0, w, h, 0, 0, bmp_pkg::HDR_SIZE_CORE);
      else if (r < 55) build_file(0, bmp_pkg::BPP_24, 0, w, h, 0, 1, bmp_pkg::HDR_SIZE_INFO);
      else if (r < 60) build_file(0, bmp_pkg::BPP_24, 0, w, h, 0, 0, $urandom);
      else if (r < 65) build_file($urandom_range(1), 16'($urandom_range(1, 7) * 4), 0, w, h,
                                  0, 0, bmp_pkg::HDR_SIZE_INFO);
      else if (r < 69) build_file(0, bmp_pkg::BPP_24, $urandom_range(1, 3), w, h, 0, 0,
                                  bmp_pkg::HDR_SIZE_INFO);
      else if (r < 73) build_file(0, bmp_pkg::BPP_24, 0,
                                  $urandom_range(1) ? 32'hFFFF_FFFE : 4097, h,
                                  0, 0, bmp_pkg::HDR_SIZE_INFO);
      else if (r < 76) build_file(0, bmp_pkg::BPP_8, 0, w, h, $urandom_range(257, 9000), 0,
                                  bmp_pkg::HDR_SIZE_INFO);
      else if (r < 79) build_file($urandom_range(1), bmp_pkg::BPP_24, 0,
                                  $urandom_range(1) ? 0 : w, 0, 0, 0,
                                  $urandom_range(1) ? bmp_pkg::HDR_SIZE_CORE
                                                    : bmp_pkg::HDR_SIZE_INFO);
      else build_file(0, $urandom_range(1) ? bmp_pkg::BPP_8 : bmp_pkg::BPP_24, 0, w, h,
                      $urandom_range(1, 8), 0, bmp_pkg::HDR_SIZE_INFO);
      if (r >= 79) send_file($urandom_range(1, img.size() - 1), 1, 0);
      else send_file(0, $urandom_range(1), $urandom_range(3) == 0 ? $urandom_range(1, 5) : 0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      // bytes before any file start
      repeat (3) put_byte(8'($urandom), 0, 0);
      build_file(0, bmp_pkg::BPP_24, 0, 3, 2, 0, 0, bmp_pkg::HDR_SIZE_INFO);
      foreach (img[i]) if (i >= 54) img[i] = (i % 2) ? 8'hFF : 8'h00;
      send_file(0, 1, 2);
      build_file(0, bmp_pkg::BPP_8, 0, 5, 2, 16, 0, bmp_pkg::HDR_SIZE_INFO);
      send_file(0, 0, 0);
      build_file(1, bmp_pkg::BPP_8, 0, 2, 3, 0, 0, bmp_pkg::HDR_SIZE_CORE);
      send_file(0, 1, 0);
      build_file(1, bmp_pkg::BPP_24, 0, 1, 1, 0, 0, bmp_pkg::HDR_SIZE_CORE);
      send_file(0, 1, 0);
      build_file(0, bmp_pkg::BPP_8, 0, 4096, 4096, 257, 0, bmp_pkg::HDR_SIZE_INFO);
      send_file(0, 1, 0);
      build_file(0, bmp_pkg::BPP_24, 0, 4, 4097, 0, 0, bmp_pkg::HDR_SIZE_INFO);
      send_file(0, 1, 0);
      build_file(0, bmp_pkg::BPP_24, 0, 2, 2, 0, 0, bmp_pkg::HDR_SIZE_INFO);
      send_file(1, 1, 0);
      send_file(30, 1, 0);
      send_file(57, 1, 0);
      while (bytes_sent < 1700) random_file();
      req_tvalid <= 0;
      req_tlast <= 0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d files in %0d bytes: %0d pixels and %0d error results checked.",
               files_sent, bytes_sent, pixels_seen, errors_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/bmp_pkg.sv
sv/bmp_byte_stream_decoder.sv
sv/bmp_checker.sv
sim/bmp_pixel_checker.sv
sim/tb_bmp_byte_stream_decoder.sv
